// ----- src/clrp_pkg.sv -----
// ----------------------------------------------------------------------------
// clrp_pkg
// Shared types, constants and saturating helpers for the cumulative
// log-binned radial profile block.
// ----------------------------------------------------------------------------
package clrp_pkg;

  localparam int BINS  = 128;
  localparam int BIN_W = $clog2(BINS);
  localparam int CNT_W = BIN_W + 1;

  localparam logic [47:0] W48_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] C32_MAX = 32'hFFFF_FFFF;

  // Weight denominator: 123*16384 + 114*electron_abundance.
  localparam logic [23:0] DEN_BASE = 24'd2015232;
  localparam logic [23:0] DEN_XA   = 24'd114;

  localparam int QDEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_LOG_MIN   = 2'd0,
    REG_LOG_MAX   = 2'd1,
    REG_INV_WIDTH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic signed [23:0] log_min;
    logic signed [23:0] log_max;
    logic [31:0]        inv_width;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] mass;
    logic [31:0] energy;
    logic [23:0] den;
    logic [31:0] rsq;
    logic [6:0]  bin_index;
  } q_item_t;

  typedef struct packed {
    logic [1:0] count;
  } front_status_t;

  typedef struct packed {
    logic [47:0]      y;
    logic             keep;
    logic [BIN_W-1:0] idx;
  } calc_res_t;

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? W48_MAX : s[47:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? C32_MAX : s[31:0];
  endfunction

endpackage

// ----- src/cumulative_log_radial_profile_core.sv -----
// ----------------------------------------------------------------------------
// cumulative_log_radial_profile_core
// Cumulative log-binned radial weight profile with an APB-style register port.
// ----------------------------------------------------------------------------
// Input transactions carry func, mass, energy, electron_abundance, radius_sq
// and bin_index on in_valid/in_stall. An insert (func 0) adds the particle
// weight to the running total and, unless dropped, to its radial bin and all
// bins above it; it produces no output. A read (func 1) returns one output
// transaction on out_valid/out_stall with the bin's weight and count sums and
// the running total.
// A two-entry queue takes inputs while the back end works, and one output
// register holds a result while the next item proceeds.
// An insert occupies the back end mainly for the weight divider, at four
// quotient bits per cycle over a 76-bit dividend. A read of bin b sums bins
// 0 to b, one bin memory read per cycle for the prefix sum.
// Reset clears all bins, the total and the registers.
// While out_stall is high the result stays put and the back end waits only
// when a second read result is ready.
// ----------------------------------------------------------------------------
module cumulative_log_radial_profile_core import clrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] mass,
  input  logic [31:0] energy,
  input  logic [15:0] electron_abundance,
  input  logic [31:0] radius_sq,
  input  logic [6:0]  bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] bin_weight_sum,
  output logic [31:0] bin_particle_count,
  output logic [47:0] total_weight
);

  cfg_t          cfg;
  logic          q_valid;
  q_item_t       q_item;
  logic          q_pop;
  front_status_t fstat;
  reg_idx_t      widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.log_min   <= 24'sd0;
      cfg.log_max   <= 24'sd0;
      cfg.inv_width <= 32'd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_LOG_MIN:   cfg.log_min   <= pwdata[23:0];
        REG_LOG_MAX:   cfg.log_max   <= pwdata[23:0];
        REG_INV_WIDTH: cfg.inv_width <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_LOG_MIN:   prdata = 32'(cfg.log_min);
      REG_LOG_MAX:   prdata = 32'(cfg.log_max);
      REG_INV_WIDTH: prdata = cfg.inv_width;
      default:       prdata = 32'd0;
    endcase
  end

  clrp_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .func               (func),
    .mass               (mass),
    .energy             (energy),
    .electron_abundance (electron_abundance),
    .radius_sq          (radius_sq),
    .bin_index          (bin_index),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .status             (fstat)
  );

  clrp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .cfg                (cfg),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .bin_weight_sum     (bin_weight_sum),
    .bin_particle_count (bin_particle_count),
    .total_weight       (total_weight)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.count <= 2'(QDEPTH))
    else $error("input queue holds more entries than it has");

  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid directly after reset");

  a_empty_bin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bin_particle_count == 32'd0) |-> (bin_weight_sum == 48'd0))
    else $error("bin with no particles reports weight");

  a_bin_le_total: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_weight_sum <= total_weight))
    else $error("bin weight exceeds the running total");

endmodule

// ----- src/clrp_front.sv -----
// ----------------------------------------------------------------------------
// clrp_front
// Accepts input transactions, classifies them as insert or read, forms the
// weight denominator and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module clrp_front import clrp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          func,
  input  logic [31:0]   mass,
  input  logic [31:0]   energy,
  input  logic [15:0]   electron_abundance,
  input  logic [31:0]   radius_sq,
  input  logic [6:0]    bin_index,
  output logic          q_valid,
  output q_item_t       q_item,
  input  logic          q_pop,
  output front_status_t status
);

  q_item_t    slots [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       enq;
  q_item_t    new_item;

  assign in_stall = (count == 2'(QDEPTH));
  assign enq      = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign status.count = count;

  always_comb begin
    new_item.op        = func ? OP_READ : OP_INSERT;
    new_item.mass      = mass;
    new_item.energy    = energy;
    new_item.den       = DEN_BASE + ({8'd0, electron_abundance} * DEN_XA);
    new_item.rsq       = radius_sq;
    new_item.bin_index = bin_index;
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({enq, q_pop && q_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/clrp_calc.sv -----
// ----------------------------------------------------------------------------
// clrp_calc
// Insert arithmetic: particle weight by long division (four quotient bits a
// cycle), log2 of the squared radius by repeated squaring, and bin index.
// ----------------------------------------------------------------------------
module clrp_calc import clrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  q_item_t     item,
  input  cfg_t        cfg,
  output logic        done,
  output calc_res_t   res
);

  localparam int DIV_STEPS = 19;
  localparam int LOG_STEPS = 16;

  typedef enum logic [5:0] {
    C_IDLE = 6'b000001,
    C_LOAD = 6'b000010,
    C_RUN  = 6'b000100,
    C_CMP  = 6'b001000,
    C_MUL  = 6'b010000,
    C_DONE = 6'b100000
  } cstate_t;

  cstate_t            state;
  logic [4:0]         step_cnt;
  logic [63:0]        prod;
  logic [23:0]        den_q;
  logic [75:0]        num;
  logic [23:0]        rem;
  logic [31:0]        m;
  logic [15:0]        frac;
  logic [4:0]         pos;
  logic               rzero;
  logic               beyond;
  logic               below;
  logic [24:0]        diff;
  logic [56:0]        qprod;

  logic [4:0]         lead_pos;
  logic [75:0]        num_next;
  logic [23:0]        rem_next;
  logic [63:0]        sq;
  logic [32:0]        sq_sh;
  logic [21:0]        lshift;
  logic signed [25:0] logr;
  logic signed [25:0] min_ext;
  logic signed [25:0] max_ext;
  logic signed [25:0] diff_full;
  logic [25:0]        idx_full;

  function automatic logic [4:0] find_lead(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

  assign lead_pos = find_lead(item.rsq);

  // Restoring division, four dependent steps per cycle.
  always_comb begin
    logic [24:0] shifted;
    logic [75:0] n;
    logic [23:0] r;
    n = num;
    r = rem;
    for (int k = 0; k < 4; k++) begin
      shifted = {r, n[75]};
      n = {n[74:0], 1'b0};
      if (shifted >= {1'b0, den_q}) begin
        shifted = shifted - {1'b0, den_q};
        n[0] = 1'b1;
      end
      r = shifted[23:0];
    end
    num_next = n;
    rem_next = r;
  end

  assign sq    = m * m;
  assign sq_sh = sq[63:31];

  always_comb begin
    lshift    = {1'b0, pos, frac} + 22'(1 << 19);
    logr      = $signed({5'd0, lshift[21:1]}) - 26'sd524288;
    min_ext   = 26'(cfg.log_min);
    max_ext   = 26'(cfg.log_max);
    diff_full = logr - min_ext;
    idx_full  = {1'b0, qprod[56:32]} + 26'd1;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      C_IDLE: begin
        prod     <= item.mass * item.energy;
        den_q    <= item.den;
        pos      <= lead_pos;
        rzero    <= (item.rsq == 32'd0);
        m        <= item.rsq << (5'd31 - lead_pos);
        frac     <= 16'd0;
        step_cnt <= 5'd0;
      end
      C_LOAD: begin
        // 352 * prod as a sum of shifts.
        num <= {4'd0, prod, 8'd0} + {6'd0, prod, 6'd0} + {7'd0, prod, 5'd0};
        rem <= 24'd0;
      end
      C_RUN: begin
        num      <= num_next;
        rem      <= rem_next;
        step_cnt <= step_cnt + 5'd1;
        if (step_cnt < 5'(LOG_STEPS)) begin
          if (sq_sh[32]) begin
            m    <= sq_sh[32:1];
            frac <= {frac[14:0], 1'b1};
          end else begin
            m    <= sq_sh[31:0];
            frac <= {frac[14:0], 1'b0};
          end
        end
      end
      C_CMP: begin
        beyond <= (logr > max_ext);
        below  <= (logr < min_ext);
        diff   <= diff_full[24:0];
      end
      C_MUL: begin
        qprod <= {32'd0, diff} * {25'd0, cfg.inv_width};
      end
      C_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      unique case (state)
        C_IDLE:  if (start) state <= C_LOAD;
        C_LOAD:  state <= C_RUN;
        C_RUN:   if (step_cnt == 5'(DIV_STEPS - 1)) state <= C_CMP;
        C_CMP:   state <= C_MUL;
        C_MUL:   state <= C_DONE;
        C_DONE:  state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

  assign done = (state == C_DONE);

  always_comb begin
    res.y    = (num[75:48] != 28'd0) ? W48_MAX : num[47:0];
    res.keep = rzero || (!beyond && (below || (idx_full < 26'(BINS))));
    res.idx  = (rzero || below) ? '0 : idx_full[BIN_W-1:0];
  end

endmodule

// ----- src/clrp_back.sv -----
// ----------------------------------------------------------------------------
// clrp_back
// Executes queued transactions. Bins hold per-bin increments; an insert adds
// to one entry and a read sums the entries up to the bin with saturation.
// ----------------------------------------------------------------------------
module clrp_back import clrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_item_t     q_item,
  output logic        q_pop,
  input  cfg_t        cfg,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] bin_weight_sum,
  output logic [31:0] bin_particle_count,
  output logic [47:0] total_weight
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_CALC = 5'b00010,
    B_UPD  = 5'b00100,
    B_SUM  = 5'b01000,
    B_OUT  = 5'b10000
  } bstate_t;

  bstate_t          state;
  logic [47:0]      mem_w [BINS];
  logic [31:0]      mem_c [BINS];
  logic [BINS-1:0]  vld;
  logic [47:0]      rdata_w;
  logic [31:0]      rdata_c;
  logic             rvld;
  logic [BIN_W-1:0] raddr;
  logic [BIN_W-1:0] upd_addr;
  logic [47:0]      y_q;
  logic [47:0]      total;
  logic [CNT_W-1:0] sweep_j;
  logic [CNT_W-1:0] rd_last;
  logic             rd_inrange;
  logic             rd_pend;
  logic [47:0]      acc_w;
  logic [31:0]      acc_c;
  logic             calc_start;
  logic             calc_done;
  calc_res_t        calc_res;
  logic             issue;
  logic             out_free;
  logic [10:0]      bi_ext;
  logic [47:0]      old_w;
  logic [31:0]      old_c;

  clrp_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .start (calc_start),
    .item  (q_item),
    .cfg   (cfg),
    .done  (calc_done),
    .res   (calc_res)
  );

  assign bi_ext     = {4'd0, q_item.bin_index};
  assign calc_start = (state == B_IDLE) && q_valid && (q_item.op == OP_INSERT);
  assign q_pop      = (state == B_IDLE) && q_valid;
  assign issue      = (state == B_SUM) && rd_inrange && (sweep_j <= rd_last);
  assign raddr      = (state == B_SUM) ? sweep_j[BIN_W-1:0] : calc_res.idx;
  assign out_free   = !out_valid || !out_stall;
  assign old_w      = rvld ? rdata_w : 48'd0;
  assign old_c      = rvld ? rdata_c : 32'd0;

  always_ff @(posedge clk) begin
    rdata_w <= mem_w[raddr];
    rdata_c <= mem_c[raddr];
    rvld    <= vld[raddr];
    if (state == B_UPD) begin
      mem_w[upd_addr] <= sat_add48(old_w, y_q);
      mem_c[upd_addr] <= sat_add32(old_c, 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (state == B_UPD) begin
      vld[upd_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      total     <= 48'd0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A new result may replace one that leaves in the same cycle.
      if ((state == B_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            if (q_item.op == OP_INSERT) begin
              state <= B_CALC;
            end else begin
              state      <= B_SUM;
              sweep_j    <= '0;
              rd_last    <= bi_ext[CNT_W-1:0];
              rd_inrange <= (bi_ext < 11'(BINS));
              acc_w      <= 48'd0;
              acc_c      <= 32'd0;
            end
          end
        end
        B_CALC: begin
          if (calc_done) begin
            total    <= sat_add48(total, calc_res.y);
            y_q      <= calc_res.y;
            upd_addr <= calc_res.idx;
            state    <= calc_res.keep ? B_UPD : B_IDLE;
          end
        end
        B_UPD: begin
          state <= B_IDLE;
        end
        B_SUM: begin
          rd_pend <= issue;
          if (issue) begin
            sweep_j <= sweep_j + CNT_W'(1);
          end
          if (rd_pend) begin
            acc_w <= sat_add48(acc_w, old_w);
            acc_c <= sat_add32(acc_c, old_c);
          end
          if (!issue && !rd_pend) begin
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_free) begin
            bin_weight_sum     <= acc_w;
            bin_particle_count <= acc_c;
            total_weight       <= total;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cumulative log-binned radial profile core.
// Particles and bin reads are driven with random idling on both channels;
// a scoreboard keeps its own copy of the bins and checks every read.
// ----------------------------------------------------------------------------
module tb;
  import clrp_pkg::*;

  localparam int PROFILE_BINS = 128;
  localparam int STALL_LIMIT  = 20000;

  class profile_scoreboard;
    logic signed [23:0] lo_log;
    logic signed [23:0] hi_log;
    logic [31:0]        inv_width;
    logic [47:0]        bin_w[PROFILE_BINS];
    logic [31:0]        bin_n[PROFILE_BINS];
    logic [47:0]        tot_w;
    logic [47:0]        exp_w[$];
    logic [31:0]        exp_n[$];
    logic [47:0]        exp_t[$];
    int                 errors;

    function new();
      lo_log = '0;
      hi_log = '0;
      inv_width = 32'd65536;
      tot_w = '0;
      errors = 0;
      for (int k = 0; k < PROFILE_BINS; k++) begin
        bin_w[k] = '0;
        bin_n[k] = '0;
      end
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_LOG_MIN: lo_log = v[23:0];
        REG_LOG_MAX: hi_log = v[23:0];
        REG_INV_WIDTH: inv_width = v;
        default: ;
      endcase
    endfunction

    function logic [47:0] add48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function logic [47:0] particle_weight(logic [31:0] m, logic [31:0] e, logic [15:0] xa);
      logic [63:0]  den;
      logic [127:0] y;
      den = 64'd2015232 + 64'd114 * xa;
      y = ({64'd0, m} * e * 128'd352) / den;
      return (y > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : y[47:0];
    endfunction

    function logic [20:0] log2_q16(logic [31:0] v);
      int          pos;
      logic [63:0] mant;
      logic [15:0] frac;
      pos = 31;
      while (pos > 0 && !v[pos]) pos--;
      mant = ({32'd0, v} << (31 - pos)) & 64'hFFFF_FFFF;
      frac = '0;
      for (int i = 0; i < 16; i++) begin
        mant = (mant * mant) >> 31;
        frac = frac << 1;
        if (mant >= 64'h1_0000_0000) begin
          frac[0] = 1'b1;
          mant = mant >> 1;
        end
      end
      return {pos[4:0], frac};
    endfunction

    function void note_input(logic f, logic [31:0] m, logic [31:0] e, logic [15:0] xa,
                             logic [31:0] rsq, logic [6:0] b);
      logic [47:0]        y;
      longint             idx, logr, diff;
      logic [63:0]        shifted;
      logic [95:0]        prod;
      if (f == OP_READ) begin
        exp_w.push_back(bin_w[b]);
        exp_n.push_back(bin_n[b]);
        exp_t.push_back(tot_w);
        return;
      end
      y = particle_weight(m, e, xa);
      tot_w = add48(tot_w, y);
      if (rsq == 0) idx = 0;
      else begin
        shifted = log2_q16(rsq) + (64'd1 << 20) - (64'd8 << 16);
        logr = longint'(shifted >> 1) - (longint'(1) << 19);
        if (logr > longint'(hi_log)) return;
        if (logr < longint'(lo_log)) idx = 0;
        else begin
          diff = logr - longint'(lo_log);
          prod = diff * {64'd0, inv_width};
          idx = (prod >> 32) + 1;
        end
      end
      if (idx >= PROFILE_BINS) return;
      for (longint k = idx; k < PROFILE_BINS; k++) begin
        bin_w[k] = add48(bin_w[k], y);
        if (bin_n[k] != 32'hFFFF_FFFF) bin_n[k] = bin_n[k] + 1;
      end
    endfunction

    function void check_result(logic [47:0] w, logic [31:0] n, logic [47:0] t);
      if (exp_w.size() == 0) begin
        $display("%0t unexpected result w=%h n=%h t=%h", $time, w, n, t);
        errors++;
        return;
      end
      if (exp_w[0] !== w) begin
        $display("%0t bin_weight_sum exp %h got %h", $time, exp_w[0], w);
        errors++;
      end
      if (exp_n[0] !== n) begin
        $display("%0t bin_particle_count exp %h got %h", $time, exp_n[0], n);
        errors++;
      end
      if (exp_t[0] !== t) begin
        $display("%0t total_weight exp %h got %h", $time, exp_t[0], t);
        errors++;
      end
      void'(exp_w.pop_front());
      void'(exp_n.pop_front());
      void'(exp_t.pop_front());
    endfunction

    function int pending();
      return exp_w.size();
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall, func;
  logic [31:0] mass, energy, radius_sq;
  logic [15:0] electron_abundance;
  logic [6:0] bin_index;
  logic out_valid, out_stall;
  logic [47:0] bin_weight_sum, total_weight;
  logic [31:0] bin_particle_count;

  profile_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  bit hold_recv;
  int quiet_cycles;

  cumulative_log_radial_profile_core u_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; func = 1'b0; mass = '0; energy = '0;
    electron_abundance = '0; radius_sq = '0; bin_index = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_recv = 1'b0;
  end

  // Receiver: random stall, or a long hold when requested.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall)
      sb.check_result(bin_weight_sum, bin_particle_count, total_weight);
  end

  // Watchdog on transactions.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(r, v);
  endtask

  task automatic send(logic f, logic [31:0] m, logic [31:0] e, logic [15:0] xa,
                      logic [31:0] rsq, logic [6:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f; mass <= m; energy <= e; electron_abundance <= xa;
    radius_sq <= rsq; bin_index <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(f, m, e, xa, rsq, b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // Inserts give no result; let the back end finish the last one.
    repeat (200) @(posedge clk);
  endtask

  task automatic random_particle();
    logic [31:0] rsq;
    case ($urandom_range(3))
      0: rsq = $urandom;
      1: rsq = $urandom >> $urandom_range(31);
      2: rsq = 32'd1 << $urandom_range(31);
      default: rsq = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(65535, 1);
    endcase
    send(OP_INSERT, $urandom, ($urandom_range(3) == 0) ? $urandom : $urandom >> 12,
         $urandom_range(65535), rsq, $urandom_range(127));
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(2) == 0)
        send(OP_READ, $urandom, $urandom, $urandom_range(65535), $urandom,
             ($urandom_range(3) == 0) ? 7'd127 : 7'($urandom_range(15)));
      else random_particle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes and special cases with reset settings.
    send(OP_READ, 0, 0, 0, 0, 0);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 32'd0, 0);
    send(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F);
    send(OP_INSERT, 32'h8000_0000, 32'd16, 16'h4000, 32'd256, 0);
    send(OP_INSERT, 32'h1234_5678, 32'd100, 16'h1000, 32'd1, 0);
    send(OP_READ, 0, 0, 0, 0, 7'd0);
    send(OP_READ, 0, 0, 0, 0, 7'd1);
    send(OP_READ, 0, 0, 0, 0, 7'd127);
    drain();

    write_reg(REG_LOG_MIN, 32'hFF_0000 & 32'hFF_FFFF);
    write_reg(REG_LOG_MAX, 32'h0C_0000);
    write_reg(REG_INV_WIDTH, 32'h000A_0000);
    send(OP_INSERT, 32'h4000_0000, 32'd4096, 16'd0, 32'd128, 0);
    send(OP_INSERT, 32'h4000_0000, 32'd4096, 16'd0, 32'd4096, 0);
    send(OP_INSERT, 32'h4000_0000, 32'd4096, 16'd0, 32'hFFFF_FFFF, 0);
    send(OP_READ, 0, 0, 0, 0, 7'd5);
    send(OP_READ, 0, 0, 0, 0, 7'd127);
    drain();

    // Phase 1: sender idles 24%, receiver 53%; wide bins.
    send_idle_pct = 24; recv_idle_pct = 53;
    write_reg(REG_LOG_MIN, 32'hF8_0000);
    write_reg(REG_LOG_MAX, 32'h0C_0000);
    write_reg(REG_INV_WIDTH, 32'h0006_0000);
    random_phase(350);
    drain();

    // Phase 2: reversed idling; extreme register values.
    send_idle_pct = 53; recv_idle_pct = 24;
    write_reg(REG_LOG_MIN, 32'h80_0000);
    write_reg(REG_LOG_MAX, 32'h7F_FFFF);
    write_reg(REG_INV_WIDTH, 32'hFFFF_FFFF);
    random_phase(150);
    drain();
    write_reg(REG_LOG_MIN, 32'h7F_FFFF);
    write_reg(REG_LOG_MAX, 32'h80_0000);
    write_reg(REG_INV_WIDTH, 32'h0);
    random_phase(100);
    drain();

    // Phase 3: no idling, with one long receiver hold.
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_LOG_MIN, 32'h00_0000);
    write_reg(REG_LOG_MAX, 32'h10_0000);
    write_reg(REG_INV_WIDTH, 32'h0007_F000);
    hold_recv = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_phase(150);
    join
    drain();
    random_phase(280);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
